FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RSI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants of the ray / sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

    // integer bits of the Q2.F direction components
    localparam int DIR_INT_BITS = 2;

    // discriminant status carried down the square-root pipe
    typedef struct packed {
        logic hit;
        logic tangent;
    } t_flags;

endpackage

FILE: src/rsi_ifs.sv
// ----------------------------------------------------------------------------
// rsi channel interfaces
// Valid/ready channels for rays in, hit results out and the radius write.
// ----------------------------------------------------------------------------
interface rsi_ray_if import rsi_pkg::*; #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 16
);
    logic                                     valid;
    logic                                     ready;
    logic signed [COORD_BITS-1:0]             origin_x;
    logic signed [COORD_BITS-1:0]             origin_y;
    logic signed [COORD_BITS-1:0]             origin_z;
    logic signed [FRAC_BITS+DIR_INT_BITS-1:0] dir_x;
    logic signed [FRAC_BITS+DIR_INT_BITS-1:0] dir_y;
    logic signed [FRAC_BITS+DIR_INT_BITS-1:0] dir_z;
    logic signed [COORD_BITS-1:0]             center_x;
    logic signed [COORD_BITS-1:0]             center_y;
    logic signed [COORD_BITS-1:0]             center_z;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z,
        output ready
    );
endinterface

interface rsi_hit_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic                         tangent;
    logic signed [COORD_BITS+3:0] distance;

    modport source (output valid, hit, tangent, distance, input ready);
    modport sink   (input valid, hit, tangent, distance, output ready);
endinterface

interface rsi_cfg_if #(
    parameter int COORD_BITS = 24
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-2:0] sphere_radius;

    modport source (output valid, sphere_radius, input ready);
    modport sink   (input valid, sphere_radius, output ready);
endinterface

FILE: src/rsi_dot.sv
// ----------------------------------------------------------------------------
// rsi_dot
// Three stages: v = O - C, products D*v and v*v, then b (rounded) and v.v.
// ----------------------------------------------------------------------------
module rsi_dot import rsi_pkg::*; #(
    parameter  int COORD_BITS = 24,
    parameter  int FRAC_BITS  = 16,
    localparam int DIRW       = FRAC_BITS + DIR_INT_BITS,
    localparam int VW         = COORD_BITS + 1,
    localparam int BW         = COORD_BITS + 5,
    localparam int VVW        = 2 * VW
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_origin [3],
    input  logic signed [DIRW-1:0]       i_dir    [3],
    input  logic signed [COORD_BITS-1:0] i_center [3],
    output logic                         o_valid,
    output logic signed [BW-1:0]         o_b,
    output logic        [VVW-1:0]        o_vv
);

    localparam int PW   = VW + DIRW;
    localparam int DOTW = PW + 2;
    localparam int SQW  = 2 * VW;
    localparam logic signed [DOTW:0] HALF = {{DOTW{1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic [2:0] r_vld;

    logic signed [VW-1:0]   r_v  [3];
    logic signed [DIRW-1:0] r_d  [3];
    logic signed [PW-1:0]   r_dv [3];
    logic        [SQW-2:0]  r_sq [3];
    logic signed [BW-1:0]   r_b;
    logic        [VVW-1:0]  r_vv;

    logic signed [VW-1:0]   n_v  [3];
    logic signed [PW-1:0]   n_dv [3];
    logic signed [SQW-1:0]  n_sqf[3];
    logic signed [DOTW-1:0] n_dot;
    logic signed [DOTW:0]   n_dotr;
    logic        [VVW-1:0]  n_vv;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_v[i]   = VW'(i_origin[i]) - VW'(i_center[i]);
            n_dv[i]  = PW'(r_d[i]) * PW'(r_v[i]);
            n_sqf[i] = SQW'(r_v[i]) * SQW'(r_v[i]);
        end
        n_dot  = DOTW'(r_dv[0]) + DOTW'(r_dv[1]) + DOTW'(r_dv[2]);
        // round to nearest, ties up: add half an LSB then floor
        n_dotr = (DOTW + 1)'(n_dot) + HALF;
        n_vv   = VVW'(r_sq[0]) + VVW'(r_sq[1]) + VVW'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_v[i]  <= n_v[i];
                r_d[i]  <= i_dir[i];
                r_dv[i] <= n_dv[i];
                r_sq[i] <= n_sqf[i][SQW-2:0];
            end
            r_b  <= n_dotr[FRAC_BITS +: BW];
            r_vv <= n_vv;
        end
    end

    assign o_valid = r_vld[2];
    assign o_b     = r_b;
    assign o_vv    = r_vv;

endmodule

FILE: src/rsi_disc.sv
// ----------------------------------------------------------------------------
// rsi_disc
// Two stages: b*b and r*r, then delta = b*b - v.v + r*r with hit/tangent.
// ----------------------------------------------------------------------------
module rsi_disc import rsi_pkg::*; #(
    parameter  int COORD_BITS = 24,
    localparam int BW         = COORD_BITS + 5,
    localparam int VVW        = 2 * COORD_BITS + 2,
    localparam int RADW       = COORD_BITS - 1,
    localparam int RDW        = 2 * COORD_BITS + 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  logic signed [BW-1:0] i_b,
    input  logic        [VVW-1:0] i_vv,
    input  logic        [RADW-1:0] i_radius,
    output logic                 o_valid,
    output logic signed [BW-1:0] o_b,
    output logic        [RDW-1:0] o_rad,
    output t_flags               o_flags
);

    localparam int BBW = 2 * COORD_BITS + 9;
    localparam int RRW = 2 * RADW;
    localparam int DLW = RDW + 1;

    logic [1:0] r_vld;

    logic signed [BW-1:0]  r_b4;
    logic        [BBW-1:0] r_bb;
    logic        [RRW-1:0] r_rr;
    logic        [VVW-1:0] r_vv4;
    logic signed [BW-1:0]  r_b5;
    logic        [RDW-1:0] r_rad;
    t_flags                r_flags;

    logic signed [2*BW-1:0] n_bbf;
    logic        [DLW-1:0]  n_delta;
    t_flags                 n_flags;

    always_comb begin
        n_bbf           = (2 * BW)'(i_b) * (2 * BW)'(i_b);
        n_delta         = DLW'(r_bb) + DLW'(r_rr) - DLW'(r_vv4);
        n_flags.hit     = !n_delta[DLW-1];
        n_flags.tangent = (n_delta == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b4    <= i_b;
            r_bb    <= n_bbf[BBW-1:0];
            r_rr    <= RRW'(i_radius) * RRW'(i_radius);
            r_vv4   <= i_vv;
            r_b5    <= r_b4;
            r_rad   <= n_flags.hit ? n_delta[RDW-1:0] : '0;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_vld[1];
    assign o_b     = r_b5;
    assign o_rad   = r_rad;
    assign o_flags = r_flags;

endmodule

FILE: src/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined floor square root, four result bits per stage, then t = -b - s
// with saturation in the output register.
// ----------------------------------------------------------------------------
module rsi_sqrt import rsi_pkg::*; #(
    parameter  int COORD_BITS = 24,
    localparam int BW         = COORD_BITS + 5,
    localparam int RDW        = 2 * COORD_BITS + 10,
    localparam int DISTW      = COORD_BITS + 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  logic signed [BW-1:0]    i_b,
    input  logic        [RDW-1:0]   i_rad,
    input  t_flags                  i_flags,
    output logic                    o_valid,
    output logic                    o_hit,
    output logic                    o_tangent,
    output logic signed [DISTW-1:0] o_distance
);

    localparam int STEPS = 4;
    localparam int QW    = RDW / 2;
    localparam int NST   = (QW + STEPS - 1) / STEPS;
    localparam int QPW   = NST * STEPS;
    localparam int PRW   = 2 * QPW;
    localparam int REMW  = QPW + 3;
    localparam int TW    = COORD_BITS + 7;
    localparam logic signed [TW-1:0] T_MAX =
        {{(TW - DISTW + 1){1'b0}}, {(DISTW - 1){1'b1}}};
    localparam logic signed [TW-1:0] T_MIN =
        {{(TW - DISTW + 1){1'b1}}, {(DISTW - 1){1'b0}}};

    logic [NST-1:0] r_vld;

    logic        [REMW-1:0] r_rem   [NST];
    logic        [QPW-1:0]  r_root  [NST];
    logic        [PRW-1:0]  r_rad   [NST];
    logic signed [BW-1:0]   r_b     [NST];
    t_flags                 r_flags [NST];

    logic        [REMW-1:0] c_rem  [NST];
    logic        [QPW-1:0]  c_root [NST];
    logic        [PRW-1:0]  c_rad  [NST];
    logic        [REMW-1:0] n_rem  [NST];
    logic        [QPW-1:0]  n_root [NST];
    logic        [PRW-1:0]  n_rad  [NST];

    logic                    r_out_vld;
    logic                    r_hit;
    logic                    r_tan;
    logic signed [DISTW-1:0] r_dist;

    logic signed [TW-1:0] n_root_ext;
    logic signed [TW-1:0] n_b_ext;
    logic signed [TW-1:0] n_t;
    logic signed [TW-1:0] n_sat;

    // stage inputs
    always_comb begin
        c_rem[0]  = '0;
        c_root[0] = '0;
        c_rad[0]  = PRW'(i_rad);
        for (int s = 1; s < NST; s++) begin
            c_rem[s]  = r_rem[s-1];
            c_root[s] = r_root[s-1];
            c_rad[s]  = r_rad[s-1];
        end
    end

    // restoring digit-by-digit root, STEPS bits per stage
    always_comb begin
        logic [REMW-1:0] rem;
        logic [QPW-1:0]  root;
        logic [PRW-1:0]  rad;
        logic [REMW-1:0] trial;
        for (int s = 0; s < NST; s++) begin
            rem  = c_rem[s];
            root = c_root[s];
            rad  = c_rad[s];
            for (int k = 0; k < STEPS; k++) begin
                rem   = {rem[REMW-3:0], rad[PRW-1 -: 2]};
                rad   = rad << 2;
                trial = REMW'({root, 2'b01});
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[QPW-2:0], 1'b1};
                end else begin
                    root = {root[QPW-2:0], 1'b0};
                end
            end
            n_rem[s]  = rem;
            n_root[s] = root;
            n_rad[s]  = rad;
        end
    end

    always_comb begin
        n_root_ext = TW'(r_root[NST-1][QW-1:0]);
        n_b_ext    = TW'(r_b[NST-1]);
        n_t        = -n_b_ext - n_root_ext;
        if (n_t > T_MAX) begin
            n_sat = T_MAX;
        end else if (n_t < T_MIN) begin
            n_sat = T_MIN;
        end else begin
            n_sat = n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld     <= {r_vld[NST-2:0], i_valid};
            r_out_vld <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int s = 0; s < NST; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_rad[s]  <= n_rad[s];
            end
            r_b[0]     <= i_b;
            r_flags[0] <= i_flags;
            for (int s = 1; s < NST; s++) begin
                r_b[s]     <= r_b[s-1];
                r_flags[s] <= r_flags[s-1];
            end
            r_hit  <= r_flags[NST-1].hit;
            r_tan  <= r_flags[NST-1].tangent;
            r_dist <= r_flags[NST-1].hit ? n_sat[DISTW-1:0] : '0;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_hit      = r_hit;
    assign o_tangent  = r_tan;
    assign o_distance = r_dist;

endmodule

FILE: src/ray_sphere_intersect.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Streaming ray / sphere test: nearer root of |O + tD - C| = r, or a miss.
// ----------------------------------------------------------------------------
// Channels:
//   i_ray : origin, unit direction and sphere center, one test per
//           transaction (valid/ready).
//   o_res : hit, tangent and distance t (Q11.16, saturating, zero on miss),
//           one transaction per ray, in input order.
//   i_cfg : sphere radius write (unsigned Q7.16); always ready. Write it only
//           while no ray is in flight.
// Pipeline: three stages for the dot products, two for the discriminant,
//   one per four root bits of the square-root pipe and one for the output
//   register.
// Throughput: one ray per cycle unless o_res is held. Every stage moves on a
//   single advance signal, so the rate is set by the output register alone.
// Reset: clears all valid bits and loads the radius with 0.1.
// Stall: while o_res is held, the whole pipe freezes and i_ray.ready drops;
//   no transaction is dropped or repeated. Bubbles move on freely whenever
//   the output register is empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_sphere_intersect import rsi_pkg::*; #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsi_cfg_if.sink   i_cfg,
    rsi_ray_if.sink   i_ray,
    rsi_hit_if.source o_res
);

    localparam int DIRW  = FRAC_BITS + DIR_INT_BITS;
    localparam int BW    = COORD_BITS + 5;
    localparam int VVW   = 2 * COORD_BITS + 2;
    localparam int RADW  = COORD_BITS - 1;
    localparam int RDW   = 2 * COORD_BITS + 10;
    localparam int DISTW = COORD_BITS + 4;
    // 0.1 in Q.FRAC_BITS, rounded
    localparam logic [RADW-1:0] RADIUS_RESET = RADW'((2 ** FRAC_BITS + 5) / 10);

    logic            w_adv;
    logic [RADW-1:0] r_radius;

    logic signed [COORD_BITS-1:0] w_origin [3];
    logic signed [DIRW-1:0]       w_dir    [3];
    logic signed [COORD_BITS-1:0] w_center [3];

    logic                  w_dot_vld;
    logic signed [BW-1:0]  w_dot_b;
    logic        [VVW-1:0] w_dot_vv;

    logic                  w_disc_vld;
    logic signed [BW-1:0]  w_disc_b;
    logic        [RDW-1:0] w_disc_rad;
    t_flags                w_disc_flags;

    logic                    w_out_vld;
    logic                    w_out_hit;
    logic                    w_out_tan;
    logic signed [DISTW-1:0] w_out_dist;

    // single advance for the whole pipe: the output register is free or drains
    assign w_adv       = !w_out_vld || o_res.ready;
    assign i_ray.ready = w_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg.valid) begin
            r_radius <= i_cfg.sphere_radius;
        end
    end

    assign w_origin[0] = i_ray.origin_x;
    assign w_origin[1] = i_ray.origin_y;
    assign w_origin[2] = i_ray.origin_z;
    assign w_dir[0]    = i_ray.dir_x;
    assign w_dir[1]    = i_ray.dir_y;
    assign w_dir[2]    = i_ray.dir_z;
    assign w_center[0] = i_ray.center_x;
    assign w_center[1] = i_ray.center_y;
    assign w_center[2] = i_ray.center_z;

    // v = O - C, b = round(D.v), v.v
    rsi_dot #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (i_ray.valid),
        .i_origin (w_origin),
        .i_dir    (w_dir),
        .i_center (w_center),
        .o_valid  (w_dot_vld),
        .o_b      (w_dot_b),
        .o_vv     (w_dot_vv)
    );

    // delta = b*b - (v.v - r*r), sign and zero test
    rsi_disc #(
        .COORD_BITS (COORD_BITS)
    ) u_disc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (w_dot_vld),
        .i_b      (w_dot_b),
        .i_vv     (w_dot_vv),
        .i_radius (r_radius),
        .o_valid  (w_disc_vld),
        .o_b      (w_disc_b),
        .o_rad    (w_disc_rad),
        .o_flags  (w_disc_flags)
    );

    // floor sqrt(delta), t = -b - sqrt, saturate; holds the output register
    rsi_sqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_valid    (w_disc_vld),
        .i_b        (w_disc_b),
        .i_rad      (w_disc_rad),
        .i_flags    (w_disc_flags),
        .o_valid    (w_out_vld),
        .o_hit      (w_out_hit),
        .o_tangent  (w_out_tan),
        .o_distance (w_out_dist)
    );

    assign o_res.valid    = w_out_vld;
    assign o_res.hit      = w_out_hit;
    assign o_res.tangent  = w_out_tan;
    assign o_res.distance = w_out_dist;

    // a miss carries no tangent flag and a zero distance
    `RSI_ASSERT_SAME(a_miss_clean, i_clk, i_rst_n, o_res.valid && !o_res.hit, !o_res.tangent && o_res.distance == '0, "miss result with nonzero tangent or distance")
    // a tangent is a hit
    `RSI_ASSERT_SAME(a_tan_is_hit, i_clk, i_rst_n, o_res.valid && o_res.tangent, o_res.hit, "tangent flagged without hit")
    // an empty output register never blocks the input
    `RSI_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_res.valid, i_ray.ready, "input stalled while output register empty")
    // a radius write lands in the register
    `RSI_ASSERT_NEXT(a_cfg_write, i_clk, i_rst_n, i_cfg.valid, r_radius == $past(i_cfg.sphere_radius), "radius write lost")

endmodule
